// ===== src/tmwf_pkg.sv =====
// Shared types, codes and helper functions of the triangle maze wall follower.
`default_nettype none

package tmwf_pkg;

	// default grid limits
	localparam int MaxRowsDef = 64;
	localparam int MaxColsDef = 64;

	localparam int PosW = 8;
	localparam int CfgW = 7;

	// request kinds carried in tuser
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_STEP  = 2'd2;

	// result status codes
	localparam logic [2:0] STS_LOADED  = 3'd0;
	localparam logic [2:0] STS_STARTED = 3'd1;
	localparam logic [2:0] STS_BAD     = 3'd2;
	localparam logic [2:0] STS_TURNED  = 3'd3;
	localparam logic [2:0] STS_MOVED   = 3'd4;
	localparam logic [2:0] STS_EXITED  = 3'd5;
	localparam logic [2:0] STS_IDLE    = 3'd6;

	// one-hot headings, matching the border mask bits
	localparam logic [2:0] H_NONE  = 3'b000;
	localparam logic [2:0] H_LEFT  = 3'b001;
	localparam logic [2:0] H_RIGHT = 3'b010;
	localparam logic [2:0] H_VERT  = 3'b100;

	// configuration register indexes
	localparam logic [1:0] CFG_ROWS = 2'd0;
	localparam logic [1:0] CFG_COLS = 2'd1;
	localparam logic [1:0] CFG_HAND = 2'd2;

	typedef struct packed {
		logic [PosW-1:0] row;
		logic [PosW-1:0] col;
		logic [2:0]      heading;
	} walker_t;

	typedef struct packed {
		logic [2:0] status;
		logic       last;
		logic       walking;
		walker_t    pos;
	} walk_res_t;

	// position test against the effective grid size, one bit of headroom
	function automatic logic inside_grid(input logic [PosW:0] r, input logic [PosW:0] c,
			input logic [PosW-1:0] rows, input logic [PosW-1:0] cols);
		return (r != '0) && (r <= {1'b0, rows}) && (c != '0) && (c <= {1'b0, cols});
	endfunction

	// turn the heading one place, direction set by cell orientation and hand
	function automatic logic [2:0] rot_heading(input logic [2:0] h, input logic up,
			input logic rh);
		if (up == rh) begin
			return {h[0], h[2:1]};
		end
		return {h[1:0], h[2]};
	endfunction

endpackage

`default_nettype wire

// ===== src/triangle_maze_wall_follower.sv =====
// Top level of the triangle maze wall follower: request decode, control and result register.
//
//  channel  | direction | handshake                     | payload
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser action, tdata borders, start
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tuser status, tdata row col, tlast
//  cfg      | in        | cfg_we (no wait)              | cfg_index, cfg_data
//
// Load, idle, off-grid start and early exit requests are answered straight from the decode;
// other start and step requests wait for the registered read of the cell store before the
// heading and position update.
// Reset clears position, heading, walking flag and load address and sets the size registers
// to one; the cell store itself holds no reset and must be loaded before it is read.
// A waiting result holds m_axis; a new request is taken as the result register drains.
`default_nettype none

module triangle_maze_wall_follower #(
	parameter int MAX_ROWS = tmwf_pkg::MaxRowsDef,
	parameter int MAX_COLS = tmwf_pkg::MaxColsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // cell_borders[2:0], start_row[10:3], start_col[18:11]
	input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata,  // row[7:0], col[15:8]
	output logic      [2:0]  m_axis_tuser,  // status[2:0]
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [tmwf_pkg::CfgW-1:0] cfg_data
);

	localparam int Depth = MAX_ROWS * MAX_COLS;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int PosW  = tmwf_pkg::PosW;
	localparam logic [PosW-1:0] MaxRowsC = PosW'(MAX_ROWS);
	localparam logic [PosW-1:0] MaxColsC = PosW'(MAX_COLS);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic                       state_q;
	logic                       op_start_q;
	tmwf_pkg::walker_t          pos_q;
	logic                       walking_q;
	logic [AddrW-1:0]           load_addr_q;
	logic [tmwf_pkg::CfgW-1:0]  map_rows_q;
	logic [tmwf_pkg::CfgW-1:0]  map_cols_q;
	logic                       right_hand_q;

	logic                       out_valid_q;
	logic [2:0]                 out_status_q;
	logic [PosW-1:0]            out_row_q;
	logic [PosW-1:0]            out_col_q;
	logic                       out_last_q;

	logic                       s_fire;
	logic [1:0]                 action;
	logic [PosW-1:0]            start_row;
	logic [PosW-1:0]            start_col;
	logic [PosW-1:0]            eff_rows;
	logic [PosW-1:0]            eff_cols;
	logic [PosW-1:0]            sel_r;
	logic [PosW-1:0]            sel_c;
	logic [PosW-1:0]            rm1;
	logic [PosW-1:0]            cm1;
	logic [2*PosW-1:0]          idx;
	logic                       sel_ok;
	logic                       rd_en;
	logic [2:0]                 rd_cell;
	tmwf_pkg::walk_res_t        res;

	assign action    = s_axis_tuser;
	assign start_row = s_axis_tdata[10:3];
	assign start_col = s_axis_tdata[18:11];

	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// clamp the size registers to the grid limits, a zero size counting as one
	always_comb begin
		if (map_rows_q == '0) begin
			eff_rows = PosW'(1);
		end else if ({1'b0, map_rows_q} > MaxRowsC) begin
			eff_rows = MaxRowsC;
		end else begin
			eff_rows = {1'b0, map_rows_q};
		end
		if (map_cols_q == '0) begin
			eff_cols = PosW'(1);
		end else if ({1'b0, map_cols_q} > MaxColsC) begin
			eff_cols = MaxColsC;
		end else begin
			eff_cols = {1'b0, map_cols_q};
		end
	end

	// cell index of the start cell or the current cell, row-major
	assign sel_r  = (action == tmwf_pkg::ACT_START) ? start_row : pos_q.row;
	assign sel_c  = (action == tmwf_pkg::ACT_START) ? start_col : pos_q.col;
	assign rm1    = sel_r - PosW'(1);
	assign cm1    = sel_c - PosW'(1);
	assign idx    = (2*PosW)'(rm1) * (2*PosW)'(eff_cols) + (2*PosW)'(cm1);
	assign sel_ok = tmwf_pkg::inside_grid({1'b0, sel_r}, {1'b0, sel_c}, eff_rows, eff_cols);

	assign rd_en = s_fire && sel_ok &&
		((action == tmwf_pkg::ACT_START) || (action == tmwf_pkg::ACT_STEP && walking_q));

	tmwf_cell_mem #(
		.DEPTH  (Depth),
		.ADDR_W (AddrW)
	) u_mem (
		.clk   (clk),
		.we    (s_fire && action == tmwf_pkg::ACT_LOAD),
		.waddr (load_addr_q),
		.wdata (s_axis_tdata[2:0]),
		.re    (rd_en),
		.raddr (idx[AddrW-1:0]),
		.rdata (rd_cell)
	);

	tmwf_walk_eval u_eval (
		.op_start   (op_start_q),
		.mask       (rd_cell),
		.pos        (pos_q),
		.eff_rows   (eff_rows),
		.eff_cols   (eff_cols),
		.right_hand (right_hand_q),
		.res        (res)
	);

	// hold the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_rows_q   <= tmwf_pkg::CfgW'(1);
			map_cols_q   <= tmwf_pkg::CfgW'(1);
			right_hand_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tmwf_pkg::CFG_ROWS: map_rows_q   <= cfg_data;
				tmwf_pkg::CFG_COLS: map_cols_q   <= cfg_data;
				tmwf_pkg::CFG_HAND: right_hand_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// decode requests, wait on the store read and advance the walker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_start_q   <= 1'b0;
			pos_q        <= '0;
			walking_q    <= 1'b0;
			load_addr_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= tmwf_pkg::STS_LOADED;
			out_row_q    <= '0;
			out_col_q    <= '0;
			out_last_q   <= 1'b0;
		end else begin
			if (state_q == ST_READ) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res.status;
				out_row_q    <= pos_q.row;
				out_col_q    <= pos_q.col;
				out_last_q   <= res.last;
				pos_q        <= res.pos;
				walking_q    <= res.walking;
				state_q      <= ST_IDLE;
			end else if (s_fire) begin
				case (action)
					tmwf_pkg::ACT_LOAD: begin
						out_valid_q  <= 1'b1;
						out_status_q <= tmwf_pkg::STS_LOADED;
						out_row_q    <= pos_q.row;
						out_col_q    <= pos_q.col;
						out_last_q   <= 1'b0;
						load_addr_q  <= (load_addr_q == AddrW'(Depth - 1)) ?
							'0 : load_addr_q + AddrW'(1);
					end
					tmwf_pkg::ACT_START: begin
						pos_q.row <= start_row;
						pos_q.col <= start_col;
						if (sel_ok) begin
							state_q     <= ST_READ;
							op_start_q  <= 1'b1;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q  <= 1'b1;
							out_status_q <= tmwf_pkg::STS_BAD;
							out_row_q    <= start_row;
							out_col_q    <= start_col;
							out_last_q   <= 1'b1;
							walking_q    <= 1'b0;
						end
					end
					tmwf_pkg::ACT_STEP: begin
						if (!walking_q) begin
							out_valid_q  <= 1'b1;
							out_status_q <= tmwf_pkg::STS_IDLE;
							out_row_q    <= pos_q.row;
							out_col_q    <= pos_q.col;
							out_last_q   <= 1'b0;
						end else if (sel_ok) begin
							state_q     <= ST_READ;
							op_start_q  <= 1'b0;
							out_valid_q <= 1'b0;
						end else begin
							// grid shrank under the walker
							out_valid_q  <= 1'b1;
							out_status_q <= tmwf_pkg::STS_EXITED;
							out_row_q    <= pos_q.row;
							out_col_q    <= pos_q.col;
							out_last_q   <= 1'b1;
							walking_q    <= 1'b0;
						end
					end
					default: begin
						out_valid_q  <= 1'b1;
						out_status_q <= tmwf_pkg::STS_IDLE;
						out_row_q    <= pos_q.row;
						out_col_q    <= pos_q.col;
						out_last_q   <= 1'b0;
					end
				endcase
			end else if (m_axis_tready) begin
				// drop the result once it is taken
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {out_col_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// the result register must be free whenever a store read completes
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !out_valid_q)
		else $error("store read completes while a result still waits");

	// a walking walker always holds exactly one heading
	a_heading_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		walking_q |-> $onehot(pos_q.heading))
		else $error("walker heading is not one-hot");

	// an ending result leaves the walker stopped
	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && res.last) |=> !walking_q)
		else $error("walker still walking after exit or bad start");

	// tlast marks only exits and bad starts
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |->
			(out_status_q == tmwf_pkg::STS_EXITED || out_status_q == tmwf_pkg::STS_BAD))
		else $error("tlast on a result that does not end the walk");
`endif

endmodule

`default_nettype wire

// ===== src/tmwf_cell_mem.sv =====
// Border mask store: one write port, one registered read port.
`default_nettype none

module tmwf_cell_mem #(
	parameter int DEPTH  = tmwf_pkg::MaxRowsDef * tmwf_pkg::MaxColsDef,
	parameter int ADDR_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [2:0]        wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [2:0]        rdata
);

	logic [2:0] mem [DEPTH];

	// write a loaded mask
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, updated only while re is set
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tmwf_walk_eval.sv =====
// Start and step evaluation on the cell mask read back from the store.
`default_nettype none

module tmwf_walk_eval (
	input  wire logic                    op_start,
	input  wire logic [2:0]              mask,
	input  wire tmwf_pkg::walker_t       pos,
	input  wire logic [tmwf_pkg::PosW-1:0] eff_rows,
	input  wire logic [tmwf_pkg::PosW-1:0] eff_cols,
	input  wire logic                    right_hand,
	output tmwf_pkg::walk_res_t          res
);

	logic                    odd;
	logic [2:0]              h_entry;
	logic                    hit_wall;
	logic [tmwf_pkg::PosW:0] nr;
	logic [tmwf_pkg::PosW:0] nc;
	logic [2:0]              h_flip;

	assign odd      = pos.row[0] ^ pos.col[0];
	assign hit_wall = |(mask & pos.heading);

	// pick the first heading from the maze edge and the cell orientation
	always_comb begin
		h_entry = tmwf_pkg::H_NONE;
		if (pos.row[0] && pos.col == 8'd1 && !mask[0]) begin
			h_entry = right_hand ? tmwf_pkg::H_RIGHT : tmwf_pkg::H_VERT;
		end else if (!pos.row[0] && pos.col == 8'd1 && !mask[0]) begin
			h_entry = right_hand ? tmwf_pkg::H_VERT : tmwf_pkg::H_RIGHT;
		end else if (pos.row == 8'd1 && pos.col[0] && !mask[2]) begin
			h_entry = right_hand ? tmwf_pkg::H_LEFT : tmwf_pkg::H_RIGHT;
		end else if (pos.row == eff_rows && odd && !mask[2]) begin
			h_entry = right_hand ? tmwf_pkg::H_RIGHT : tmwf_pkg::H_LEFT;
		end else if (pos.col == eff_cols && !odd && !mask[1]) begin
			h_entry = right_hand ? tmwf_pkg::H_VERT : tmwf_pkg::H_LEFT;
		end else if (pos.col == eff_cols && odd && !mask[1]) begin
			h_entry = right_hand ? tmwf_pkg::H_LEFT : tmwf_pkg::H_VERT;
		end
	end

	// neighbour across the edge faced; the flipped heading points back the same way
	always_comb begin
		nr     = {1'b0, pos.row};
		nc     = {1'b0, pos.col};
		h_flip = pos.heading;
		case (pos.heading)
			tmwf_pkg::H_LEFT: begin
				nc     = {1'b0, pos.col} - 9'd1;
				h_flip = tmwf_pkg::H_RIGHT;
			end
			tmwf_pkg::H_RIGHT: begin
				nc     = {1'b0, pos.col} + 9'd1;
				h_flip = tmwf_pkg::H_LEFT;
			end
			tmwf_pkg::H_VERT: begin
				nr = odd ? {1'b0, pos.row} + 9'd1 : {1'b0, pos.row} - 9'd1;
			end
			default: begin
				nr = {1'b0, pos.row};
			end
		endcase
	end

	// assemble the outcome
	always_comb begin
		res.pos     = pos;
		res.walking = 1'b1;
		res.last    = 1'b0;
		res.status  = tmwf_pkg::STS_TURNED;
		if (op_start) begin
			if (h_entry == tmwf_pkg::H_NONE) begin
				res.status  = tmwf_pkg::STS_BAD;
				res.last    = 1'b1;
				res.walking = 1'b0;
			end else begin
				res.status      = tmwf_pkg::STS_STARTED;
				res.pos.heading = h_entry;
			end
		end else if (hit_wall) begin
			res.pos.heading = tmwf_pkg::rot_heading(pos.heading, odd, right_hand);
		end else begin
			res.pos.row     = nr[tmwf_pkg::PosW-1:0];
			res.pos.col     = nc[tmwf_pkg::PosW-1:0];
			res.pos.heading = tmwf_pkg::rot_heading(h_flip, !odd, right_hand);
			if (tmwf_pkg::inside_grid(nr, nc, eff_rows, eff_cols)) begin
				res.status = tmwf_pkg::STS_MOVED;
			end else begin
				res.status  = tmwf_pkg::STS_EXITED;
				res.last    = 1'b1;
				res.walking = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench of the triangle maze wall follower: directed table, then random walks.
`timescale 1ns / 100ps

module tb_top;

	localparam int          CELLS       = 4096;
	localparam int          FILL_CELLS  = 256;
	localparam int          CYCLE_LIMIT = 600_000;
	localparam int          PHASES      = 8;
	localparam logic [1:0]  ACT_NONE    = 2'd3;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] row;
		logic [7:0] col;
		logic       last;
	} maze_reply_t;

	// one line of the directed table: a register write or a request
	typedef struct packed {
		bit          is_cfg;
		bit          fixed;
		logic [1:0]  code;
		logic [6:0]  value;
		logic [2:0]  borders;
		logic [7:0]  srow;
		logic [7:0]  scol;
		maze_reply_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [tmwf_pkg::CfgW-1:0] cfg_data = '0;

	// walker shadow state
	logic [2:0]  maze_cells [0:CELLS-1];
	logic [11:0] fill_ptr = '0;
	logic [7:0]  walk_row = '0;
	logic [7:0]  walk_col = '0;
	logic [2:0]  walk_head = tmwf_pkg::H_NONE;
	bit          walk_on = 1'b0;
	logic [6:0]  grid_rows_reg = 7'd1;
	logic [6:0]  grid_cols_reg = 7'd1;
	bit          right_rule = 1'b0;

	maze_reply_t replies_due [$];
	plan_row_t   plan [$];
	maze_reply_t no_reply = '0;
	int          mismatches = 0;
	int          busy_items = 0;
	int          sink_hold = 0;
	int          taken_count = 0;
	int          seen_taken = 0;
	bit          idle_on = 1'b1;

	int phase_rows [PHASES] = '{16, 127, 0, 1, 64, 5, 2, 0};
	int phase_cols [PHASES] = '{16, 2, 0, 100, 1, 7, 2, 0};
	int phase_hand [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};

	triangle_maze_wall_follower dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // cell_borders[2:0], start_row[10:3], start_col[18:11]
		.s_axis_tuser  (s_axis_tuser),  // action[1:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),  // row[7:0], col[15:8]
		.m_axis_tuser  (m_axis_tuser),  // status[2:0]
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// grid size as the block sees it, clamped to 1..64
	function automatic int eff_rows();
		if (grid_rows_reg == 0) return 1;
		return (grid_rows_reg > 64) ? 64 : int'(grid_rows_reg);
	endfunction

	function automatic int eff_cols();
		if (grid_cols_reg == 0) return 1;
		return (grid_cols_reg > 64) ? 64 : int'(grid_cols_reg);
	endfunction

	function automatic bit on_grid(int r, int c);
		return r >= 1 && r <= eff_rows() && c >= 1 && c <= eff_cols();
	endfunction

	// only called for cells on the grid
	function automatic bit blocked(int r, int c, logic [2:0] side);
		int idx;
		idx = ((r - 1) * eff_cols() + (c - 1)) % CELLS;
		return (maze_cells[idx] & side) != 0;
	endfunction

	// first heading from the edge the start cell lies on and its orientation
	function automatic logic [2:0] entry_heading(int r, int c);
		bit odd;
		odd = ((r + c) & 1) != 0;
		if ((r & 1) && c == 1 && !blocked(r, c, tmwf_pkg::H_LEFT))
			return right_rule ? tmwf_pkg::H_RIGHT : tmwf_pkg::H_VERT;
		if (!(r & 1) && c == 1 && !blocked(r, c, tmwf_pkg::H_LEFT))
			return right_rule ? tmwf_pkg::H_VERT : tmwf_pkg::H_RIGHT;
		if (r == 1 && (c & 1) && !blocked(r, c, tmwf_pkg::H_VERT))
			return right_rule ? tmwf_pkg::H_LEFT : tmwf_pkg::H_RIGHT;
		if (r == eff_rows() && odd && !blocked(r, c, tmwf_pkg::H_VERT))
			return right_rule ? tmwf_pkg::H_RIGHT : tmwf_pkg::H_LEFT;
		if (c == eff_cols() && !odd && !blocked(r, c, tmwf_pkg::H_RIGHT))
			return right_rule ? tmwf_pkg::H_VERT : tmwf_pkg::H_LEFT;
		if (c == eff_cols() && odd && !blocked(r, c, tmwf_pkg::H_RIGHT))
			return right_rule ? tmwf_pkg::H_LEFT : tmwf_pkg::H_VERT;
		return tmwf_pkg::H_NONE;
	endfunction

	// rotate one place; sense depends on whether the cell points up and on the hand
	function automatic void turn_walker(int r, int c);
		int h;
		bit up;
		up = ((r + c) & 1) != 0;
		h = int'(walk_head);
		if (up == right_rule) begin
			h = h >> 1;
			if (h == 0) h = int'(tmwf_pkg::H_VERT);
		end else begin
			h = (h << 1) & 15;
			if (h == 8) h = int'(tmwf_pkg::H_LEFT);
		end
		walk_head = h[2:0];
	endfunction

	// apply one request to the shadow state and return the reply it should produce
	function automatic maze_reply_t advance_walker(logic [1:0] act, logic [2:0] brd,
			logic [7:0] sr, logic [7:0] sc);
		maze_reply_t rep;
		logic [2:0] h;
		int r, c, nr, nc;
		rep.status = tmwf_pkg::STS_IDLE;
		rep.row = walk_row;
		rep.col = walk_col;
		rep.last = 1'b0;
		case (act)
			tmwf_pkg::ACT_LOAD: begin
				maze_cells[fill_ptr] = brd;
				fill_ptr = fill_ptr + 1'b1;
				rep.status = tmwf_pkg::STS_LOADED;
			end
			tmwf_pkg::ACT_START: begin
				walk_row = sr;
				walk_col = sc;
				rep.row = sr;
				rep.col = sc;
				h = on_grid(int'(sr), int'(sc)) ? entry_heading(int'(sr), int'(sc)) :
					tmwf_pkg::H_NONE;
				if (h == tmwf_pkg::H_NONE) begin
					walk_on = 1'b0;
					rep.status = tmwf_pkg::STS_BAD;
					rep.last = 1'b1;
				end else begin
					walk_head = h;
					walk_on = 1'b1;
					rep.status = tmwf_pkg::STS_STARTED;
				end
			end
			tmwf_pkg::ACT_STEP: begin
				if (walk_on) begin
					r = int'(walk_row);
					c = int'(walk_col);
					if (!on_grid(r, c)) begin
						// grid shrank under the walker
						walk_on = 1'b0;
						rep.status = tmwf_pkg::STS_EXITED;
						rep.last = 1'b1;
					end else if (blocked(r, c, walk_head)) begin
						turn_walker(r, c);
						rep.status = tmwf_pkg::STS_TURNED;
					end else begin
						nr = r;
						nc = c;
						if (walk_head == tmwf_pkg::H_LEFT) nc = c - 1;
						else if (walk_head == tmwf_pkg::H_RIGHT) nc = c + 1;
						else if (walk_head == tmwf_pkg::H_VERT)
							nr = ((r + c) & 1) ? r + 1 : r - 1;
						// crossing a side wall swaps which side it is seen from
						if (walk_head == tmwf_pkg::H_RIGHT) walk_head = tmwf_pkg::H_LEFT;
						else if (walk_head == tmwf_pkg::H_LEFT) walk_head = tmwf_pkg::H_RIGHT;
						turn_walker(nr, nc);
						walk_row = nr[7:0];
						walk_col = nc[7:0];
						if (!on_grid(nr, nc)) begin
							walk_on = 1'b0;
							rep.status = tmwf_pkg::STS_EXITED;
							rep.last = 1'b1;
						end else begin
							rep.status = tmwf_pkg::STS_MOVED;
						end
					end
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t ns: %s", $time, what);
	endtask

	// offer one request, after a random gap while idle_on is set, and log its reply once taken
	task automatic send_request(input logic [1:0] act, input logic [2:0] brd,
			input logic [7:0] sr, input logic [7:0] sc, input bit use_fixed,
			input maze_reply_t fixed_reply, output maze_reply_t reply);
		int gap;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {5'd0, sc, sr, brd};
		s_axis_tuser = act;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		reply = advance_walker(act, brd, sr, sc);
		if (reply.status != tmwf_pkg::STS_IDLE) busy_items++;
		replies_due.push_back(use_fixed ? fixed_reply : reply);
	endtask

	// drop valid and hold until every reply is back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_setting(input logic [1:0] idx, input logic [6:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			tmwf_pkg::CFG_ROWS: grid_rows_reg = val;
			tmwf_pkg::CFG_COLS: grid_cols_reg = val;
			tmwf_pkg::CFG_HAND: right_rule = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic plan_cfg(input logic [1:0] idx, input logic [6:0] val);
		plan_row_t pr;
		pr = '0;
		pr.is_cfg = 1'b1;
		pr.code = idx;
		pr.value = val;
		plan.push_back(pr);
	endtask

	task automatic plan_req(input logic [1:0] act, input logic [2:0] brd,
			input logic [7:0] sr, input logic [7:0] sc);
		plan_row_t pr;
		pr = '0;
		pr.code = act;
		pr.borders = brd;
		pr.srow = sr;
		pr.scol = sc;
		plan.push_back(pr);
	endtask

	task automatic plan_fixed(input logic [1:0] act, input logic [2:0] brd,
			input logic [7:0] sr, input logic [7:0] sc, input logic [2:0] sts,
			input logic [7:0] row, input logic [7:0] col, input logic last);
		plan_row_t pr;
		pr = '0;
		pr.fixed = 1'b1;
		pr.code = act;
		pr.borders = brd;
		pr.srow = sr;
		pr.scol = sc;
		pr.want.status = sts;
		pr.want.row = row;
		pr.want.col = col;
		pr.want.last = last;
		plan.push_back(pr);
	endtask

	// random walks from edge cells, mixed with loads and noise
	task automatic random_phase(input int budget);
		int stop_at, kind, steps, r, c;
		maze_reply_t rep;
		stop_at = busy_items + budget;
		while (busy_items < stop_at) begin
			if ($urandom_range(0, 39) == 0) wait_drained();
			kind = $urandom_range(0, 9);
			if (kind <= 6) begin
				r = $urandom_range(1, eff_rows());
				c = $urandom_range(1, eff_cols());
				case ($urandom_range(0, 3))
					0: c = 1;
					1: r = 1;
					2: r = eff_rows();
					default: c = eff_cols();
				endcase
				send_request(tmwf_pkg::ACT_START, 3'($urandom_range(0, 7)), 8'(r), 8'(c),
					1'b0, no_reply, rep);
				steps = $urandom_range(1, 40);
				while (steps > 0 && !rep.last) begin
					if ($urandom_range(0, 9) == 0)
						send_request(tmwf_pkg::ACT_LOAD, 3'($urandom_range(0, 7)),
							8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							1'b0, no_reply, rep);
					else
						send_request(tmwf_pkg::ACT_STEP, 3'($urandom_range(0, 7)),
							8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
							1'b0, no_reply, rep);
					steps--;
				end
			end else if (kind == 7) begin
				repeat ($urandom_range(1, 4))
					send_request(tmwf_pkg::ACT_LOAD, 3'($urandom_range(0, 7)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						1'b0, no_reply, rep);
			end else begin
				send_request(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'b0, no_reply, rep);
			end
		end
	endtask

	// draw a stall after each taken reply and release the sink once it runs out
	always @(negedge clk) begin
		if (taken_count != seen_taken) begin
			seen_taken = taken_count;
			sink_hold = idle_on ? $urandom_range(0, 17) : 0;
		end
		if (sink_hold != 0) begin
			m_axis_tready = 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	// compare each taken reply with the oldest one due
	always @(posedge clk) begin
		maze_reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (replies_due.size() == 0) begin
				report_mismatch($sformatf("reply with nothing due, status %0d", m_axis_tuser));
			end else begin
				want = replies_due.pop_front();
				if (m_axis_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
				if (m_axis_tdata[7:0] !== want.row)
					report_mismatch($sformatf("row %0d, want %0d", m_axis_tdata[7:0], want.row));
				if (m_axis_tdata[15:8] !== want.col)
					report_mismatch($sformatf("col %0d, want %0d", m_axis_tdata[15:8], want.col));
				if (m_axis_tlast !== want.last)
					report_mismatch($sformatf("last %0d, want %0d", m_axis_tlast, want.last));
			end
			taken_count++;
		end
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		maze_reply_t rep;
		for (int i = 0; i < CELLS; i++) maze_cells[i] = '0;

		// directed table; starts at 1x1 grid, left hand
		plan_fixed(tmwf_pkg::ACT_STEP,  3'd0, 8'd0,   8'd0,   tmwf_pkg::STS_IDLE,
			8'd0,   8'd0,   1'b0);
		plan_fixed(ACT_NONE,            3'd7, 8'd255, 8'd255, tmwf_pkg::STS_IDLE,
			8'd0,   8'd0,   1'b0);
		plan_fixed(tmwf_pkg::ACT_START, 3'd0, 8'd0,   8'd0,   tmwf_pkg::STS_BAD,
			8'd0,   8'd0,   1'b1);
		plan_fixed(tmwf_pkg::ACT_START, 3'd7, 8'd255, 8'd255, tmwf_pkg::STS_BAD,
			8'd255, 8'd255, 1'b1);
		plan_fixed(tmwf_pkg::ACT_STEP,  3'd7, 8'd0,   8'd0,   tmwf_pkg::STS_IDLE,
			8'd255, 8'd255, 1'b0);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd7, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd255, 8'd255, 1'b0);
		// walled-in single cell
		plan_fixed(tmwf_pkg::ACT_START, 3'd0, 8'd1,   8'd1,   tmwf_pkg::STS_BAD,
			8'd1,   8'd1,   1'b1);
		plan_fixed(tmwf_pkg::ACT_START, 3'd0, 8'd1,   8'd200, tmwf_pkg::STS_BAD,
			8'd1,   8'd200, 1'b1);
		// 2x3 maze
		plan_cfg(tmwf_pkg::CFG_ROWS, 7'd2);
		plan_cfg(tmwf_pkg::CFG_COLS, 7'd3);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd2, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd1,   8'd200, 1'b0);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd0, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd1,   8'd200, 1'b0);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd1, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd1,   8'd200, 1'b0);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd4, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd1,   8'd200, 1'b0);
		plan_fixed(tmwf_pkg::ACT_LOAD,  3'd0, 8'd0,   8'd0,   tmwf_pkg::STS_LOADED,
			8'd1,   8'd200, 1'b0);
		plan_fixed(tmwf_pkg::ACT_START, 3'd0, 8'd1,   8'd3,   tmwf_pkg::STS_STARTED,
			8'd1,   8'd3,   1'b0);
		plan_req(tmwf_pkg::ACT_STEP, 3'd0, 8'd0, 8'd0);
		plan_fixed(tmwf_pkg::ACT_START, 3'd0, 8'd1,   8'd3,   tmwf_pkg::STS_STARTED,
			8'd1,   8'd3,   1'b0);
		// shrink the grid under the walker
		plan_cfg(tmwf_pkg::CFG_COLS, 7'd1);
		plan_fixed(tmwf_pkg::ACT_STEP,  3'd0, 8'd0,   8'd0,   tmwf_pkg::STS_EXITED,
			8'd1,   8'd3,   1'b1);
		plan_cfg(tmwf_pkg::CFG_COLS, 7'd3);
		plan_cfg(tmwf_pkg::CFG_HAND, 7'd1);
		plan_req(tmwf_pkg::ACT_START, 3'd0, 8'd2, 8'd1);
		repeat (4) plan_req(tmwf_pkg::ACT_STEP, 3'd5, 8'd170, 8'd85);
		plan_req(tmwf_pkg::ACT_START, 3'd0, 8'd1, 8'd2);
		plan_req(tmwf_pkg::ACT_START, 3'd0, 8'd2, 8'd3);
		repeat (2) plan_req(tmwf_pkg::ACT_STEP, 3'd2, 8'd85, 8'd170);

		// reset
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained();
				write_setting(plan[i].code, plan[i].value);
			end else begin
				send_request(plan[i].code, plan[i].borders, plan[i].srow, plan[i].scol,
					plan[i].fixed, plan[i].want, rep);
			end
		end

		// fill every cell the random grids can reach, back to back
		wait_drained();
		write_setting(tmwf_pkg::CFG_ROWS, 7'd64);
		write_setting(tmwf_pkg::CFG_COLS, 7'd64);
		idle_on = 1'b0;
		repeat (FILL_CELLS)
			send_request(tmwf_pkg::ACT_LOAD, 3'($urandom_range(0, 7)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0, no_reply, rep);

		// random walks over a range of grid sizes and both hands
		for (int k = 0; k < PHASES; k++) begin
			wait_drained();
			if (k == PHASES - 1) begin
				write_setting(tmwf_pkg::CFG_ROWS, 7'($urandom_range(1, 12)));
				write_setting(tmwf_pkg::CFG_COLS, 7'($urandom_range(1, 12)));
				write_setting(tmwf_pkg::CFG_HAND, 7'($urandom_range(0, 1)));
			end else begin
				write_setting(tmwf_pkg::CFG_ROWS, 7'(phase_rows[k]));
				write_setting(tmwf_pkg::CFG_COLS, 7'(phase_cols[k]));
				write_setting(tmwf_pkg::CFG_HAND, 7'(phase_hand[k]));
			end
			idle_on = (k != 6);
			random_phase(60);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
